>>> hw/rtl/uvsc_pkg.sv
// ----------------------------------------------------------------------------
// uvsc_pkg
// Shared types, codes and helpers of the uintvar stream codec.
// ----------------------------------------------------------------------------
package uvsc_pkg;

   typedef enum logic [2:0] {
      KIND_BYTE    = 3'd0,
      KIND_VALUE   = 3'd1,
      KIND_SIZE    = 3'd2,
      KIND_NOROOM  = 3'd3,
      KIND_TOOLONG = 3'd4
   } kind_type;

   localparam logic [1:0] MODE_DECODE = 2'd0;
   localparam logic [1:0] MODE_ENCODE = 2'd1;
   localparam logic [1:0] MODE_SIZE   = 2'd2;

   localparam logic CSR_MODE   = 1'b0;
   localparam logic CSR_BUFLEN = 1'b1;

   localparam int          CSR_DATA_BITS = 16;
   localparam logic [15:0] BUFLEN_RESET  = 16'hffff;
   localparam logic [2:0]  MAX_GROUPS    = 3'd5;

   typedef struct packed {
      logic accept;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic enc_multi;
      logic enc_last;
   } status_type;

   function automatic logic [2:0] enc_len(input logic [31:0] v);
      logic [2:0] n;
      if (v < 32'h80) n = 3'd1;
      else if (v < 32'h4000) n = 3'd2;
      else if (v < 32'h200000) n = 3'd3;
      else if (v < 32'h10000000) n = 3'd4;
      else n = 3'd5;
      return n;
   endfunction

   function automatic logic [6:0] group_sel(input logic [31:0] v, input logic [2:0] k);
      logic [6:0] g;
      case (k)
         3'd0: g = v[6:0];
         3'd1: g = v[13:7];
         3'd2: g = v[20:14];
         3'd3: g = v[27:21];
         3'd4: g = {3'b000, v[31:28]};
         default: g = 7'd0;
      endcase
      return g;
   endfunction

endpackage

>>> hw/rtl/uintvar_stream_codec_top.sv
// ----------------------------------------------------------------------------
// uintvar_stream_codec_top
// Uintvar codec: decode bytes to values, encode values to bytes, or size.
// ----------------------------------------------------------------------------
// Decode, size, error and restart-only items do not hold the input, so a new
// beat can be accepted every cycle while the output register drains. An
// encode item of 2 to 5 bytes holds the input until its last byte is loaded,
// since the result port carries one byte per beat; the encoded length is 1
// to 5 bytes. Write the mode and buffer length registers only while the
// block is idle. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module uintvar_stream_codec_top
   import uvsc_pkg::*;
#(
   parameter int POSITION_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart,
   input  logic [7:0]               req_in_byte,
   input  logic [31:0]              req_in_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_out_kind,
   output logic [7:0]               rsp_out_byte,
   output logic [31:0]              rsp_out_value,
   output logic [19:0]              rsp_position,
   output logic                     rsp_last,
   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   uvsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   uvsc_dp #(
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_restart   (req_restart),
      .req_in_byte   (req_in_byte),
      .req_in_value  (req_in_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_value (rsp_out_value),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last)
   );

   a_no_accept_on_blocked_out: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !(rsp_valid && rsp_stall))
      else $error("input beat accepted while result beat blocked");

   a_hold_input_mid_encode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("input open while encode bytes remain");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_kind <= KIND_TOOLONG))
      else $error("result kind out of range");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.emit))
      else $error("accept and emit in the same cycle");

endmodule

>>> hw/rtl/uvsc_ctrl.sv
// ----------------------------------------------------------------------------
// uvsc_ctrl
// Controller: input handshake, encode byte sequencing, result valid.
// ----------------------------------------------------------------------------
module uvsc_ctrl
   import uvsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic {S_IDLE, S_ENC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      out_load;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      cmd.accept = (state_ff == S_IDLE) && req_valid && out_free;
      cmd.emit   = (state_ff == S_ENC) && out_free;
      req_stall  = (state_ff != S_IDLE) || !out_free;
   end

   always_comb begin
      out_load = cmd.emit || (cmd.accept && sts.has_result);

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept && sts.enc_multi) state_in = S_ENC;
         end
         S_ENC: begin
            if (cmd.emit && sts.enc_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/uvsc_dp.sv
// ----------------------------------------------------------------------------
// uvsc_dp
// Datapath: registers, position, accumulator, byte formation, result beat.
// ----------------------------------------------------------------------------
module uvsc_dp
   import uvsc_pkg::*;
#(
   parameter int POSITION_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_restart,
   input  logic [7:0]               req_in_byte,
   input  logic [31:0]              req_in_value,
   input  cmd_type                  cmd,
   output status_type               sts,
   output logic [2:0]               rsp_out_kind,
   output logic [7:0]               rsp_out_byte,
   output logic [31:0]              rsp_out_value,
   output logic [19:0]              rsp_position,
   output logic                     rsp_last
);

   localparam int PW = (POSITION_BITS > 20) ? POSITION_BITS : 20;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [1:0]               mode_ff;
   logic [15:0]              len_ff;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_eff, pos_inc;
   logic [31:0]              acc_ff, acc_in, acc_eff, acc_shift;
   logic [2:0]               gc_ff, gc_in, gc_eff, gc_inc;
   logic [31:0]              val_ff, val_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [2:0]               n;
   logic [POSITION_BITS:0]   sum, len_ext;
   logic                     enc_noroom, dec_empty;
   logic                     res_valid, res_last;
   kind_type                 res_kind;
   logic [7:0]               res_byte;
   logic [31:0]              res_value;
   logic [PW-1:0]            pos_wide;

   kind_type    kind_ff;
   logic [7:0]  byte_ff;
   logic [31:0] value_ff;
   logic [19:0] opos_ff;
   logic        last_ff;

   always_comb begin
      pos_eff    = req_restart ? '0 : pos_ff;
      acc_eff    = req_restart ? 32'd0 : acc_ff;
      gc_eff     = req_restart ? 3'd0 : gc_ff;
      pos_inc    = pos_eff + POS_ONE;
      acc_shift  = {acc_eff[24:0], req_in_byte[6:0]};
      gc_inc     = gc_eff + 3'd1;
      n          = enc_len(req_in_value);
      sum        = {1'b0, pos_eff} + (POSITION_BITS+1)'(n);
      len_ext    = (POSITION_BITS+1)'(len_ff);
      enc_noroom = sum > len_ext;
      dec_empty  = {1'b0, pos_eff} >= len_ext;

      pos_in        = pos_ff;
      acc_in        = acc_ff;
      gc_in         = gc_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      res_valid     = 1'b0;
      res_kind      = KIND_BYTE;
      res_byte      = 8'd0;
      res_value     = 32'd0;
      res_last      = 1'b1;
      sts.enc_multi = 1'b0;

      if (cmd.accept) begin
         pos_in = pos_eff;
         acc_in = acc_eff;
         gc_in  = gc_eff;
         case (mode_ff)
            MODE_DECODE: begin
               res_valid = 1'b1;
               if (dec_empty) begin
                  acc_in   = 32'd0;
                  gc_in    = 3'd0;
                  res_kind = KIND_NOROOM;
               end else begin
                  pos_in = pos_inc;
                  if (gc_inc > MAX_GROUPS) begin
                     acc_in   = 32'd0;
                     gc_in    = 3'd0;
                     res_kind = KIND_TOOLONG;
                  end else if (req_in_byte[7]) begin
                     acc_in    = acc_shift;
                     gc_in     = gc_inc;
                     res_valid = 1'b0;
                  end else begin
                     acc_in    = 32'd0;
                     gc_in     = 3'd0;
                     res_kind  = KIND_VALUE;
                     res_value = acc_shift;
                  end
               end
            end
            MODE_ENCODE: begin
               res_valid = 1'b1;
               if (enc_noroom) begin
                  res_kind = KIND_NOROOM;
               end else begin
                  pos_in        = pos_inc;
                  val_in        = req_in_value;
                  cnt_in        = n - 3'd1;
                  res_byte      = {n != 3'd1, group_sel(req_in_value, n - 3'd1)};
                  res_last      = (n == 3'd1);
                  sts.enc_multi = (n != 3'd1);
               end
            end
            MODE_SIZE: begin
               res_valid = 1'b1;
               res_kind  = KIND_SIZE;
               res_value = 32'(n);
               pos_in    = sum[POSITION_BITS] ? POS_MAX : sum[POSITION_BITS-1:0];
            end
            default: begin
            end
         endcase
      end else if (cmd.emit) begin
         pos_in   = pos_ff + POS_ONE;
         cnt_in   = cnt_ff - 3'd1;
         res_byte = {cnt_ff != 3'd1, group_sel(val_ff, cnt_ff - 3'd1)};
         res_last = (cnt_ff == 3'd1);
      end

      pos_wide       = PW'(pos_in);
      sts.has_result = res_valid;
      sts.enc_last   = (cnt_ff == 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DECODE;
         len_ff  <= BUFLEN_RESET;
         pos_ff  <= '0;
         acc_ff  <= 32'd0;
         gc_ff   <= 3'd0;
         cnt_ff  <= 3'd0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_MODE:   mode_ff <= csr_wdata[1:0];
               CSR_BUFLEN: len_ff  <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         pos_ff <= pos_in;
         acc_ff <= acc_in;
         gc_ff  <= gc_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (cmd.emit || (cmd.accept && res_valid)) begin
         kind_ff  <= res_kind;
         byte_ff  <= res_byte;
         value_ff <= res_value;
         opos_ff  <= pos_wide[19:0];
         last_ff  <= res_last;
      end
   end

   assign rsp_out_kind  = kind_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_value = value_ff;
   assign rsp_position  = opos_ff;
   assign rsp_last      = last_ff;

endmodule

>>> tb/sv/tb_uintvar_stream_codec_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uintvar_stream_codec_top
// Self-checking bench for the uintvar codec. A tracker class mirrors the
// block's position, accumulator and group count, and queues the result beats
// that each accepted input beat must produce. The result port is compared
// beat by beat and field by field. The run covers a directed corner sweep,
// a back-to-back size-mode burst with no idling, and random phases. The
// random phases use well-formed uintvar runs, over-long runs and noise, with
// random gaps and stalls except in every fourth phase.
// ----------------------------------------------------------------------------
module tb_uintvar_stream_codec_top
   import uvsc_pkg::*;
();

   localparam int          CYCLE_LIMIT  = 3_000_000;
   localparam int          BURST_ITEMS  = 12;
   localparam int          RANDOM_ITEMS = 64;
   localparam int          PHASE_ITEMS  = 14;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          REPORT_LIMIT = 10;
   localparam logic [19:0] POS_MAX      = 20'hfffff;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [31:0] value;
      logic [19:0] position;
      logic        last;
   } codec_beat_type;

   class uintvar_tracker_type;
      logic [1:0]     mode    = MODE_DECODE;
      logic [15:0]    buf_len = BUFLEN_RESET;
      logic [19:0]    pos     = '0;
      logic [31:0]    acc     = '0;
      logic [2:0]     groups  = '0;
      codec_beat_type pending_beats[$];
      int             failures   = 0;
      int             checked    = 0;
      int             items_seen = 0;
      int             kind_seen[5];

      function void set_reg(logic idx, logic [15:0] data);
         if (idx == CSR_MODE) begin
            mode = data[1:0];
         end else begin
            buf_len = data;
         end
      endfunction

      function logic [2:0] encoded_length(logic [31:0] v);
         logic [2:0] n;
         n = 3'd1;
         while (n < 3'd5 && (v >> (7 * n)) != 32'd0) n = n + 3'd1;
         return n;
      endfunction

      function logic [19:0] room_left();
         if (pos >= buf_len) return '0;
         return buf_len - pos;
      endfunction

      function void push(kind_type k, logic [7:0] b, logic [31:0] v, logic lst);
         pending_beats.push_back('{kind: k, out_byte: b, value: v, position: pos, last: lst});
      endfunction

      function void accept_item(logic rs, logic [7:0] b, logic [31:0] v);
         logic [2:0]  n;
         logic [20:0] sum;
         int          i;
         items_seen++;
         n = encoded_length(v);
         if (rs) begin
            pos    = '0;
            acc    = '0;
            groups = '0;
         end
         case (mode)
            MODE_DECODE: begin
               if (pos >= buf_len) begin
                  acc    = '0;
                  groups = '0;
                  push(KIND_NOROOM, 8'd0, 32'd0, 1'b1);
               end else begin
                  pos    = pos + 1'b1;
                  acc    = {acc[24:0], b[6:0]};
                  groups = groups + 1'b1;
                  if (groups > MAX_GROUPS) begin
                     acc    = '0;
                     groups = '0;
                     push(KIND_TOOLONG, 8'd0, 32'd0, 1'b1);
                  end else if (!b[7]) begin
                     push(KIND_VALUE, 8'd0, acc, 1'b1);
                     acc    = '0;
                     groups = '0;
                  end
               end
            end
            MODE_ENCODE: begin
               if (room_left() < n) begin
                  push(KIND_NOROOM, 8'd0, 32'd0, 1'b1);
               end else begin
                  for (i = n - 1; i >= 0; i--) begin
                     pos = pos + 1'b1;
                     push(KIND_BYTE, {(i != 0), 7'(v >> (7 * i))}, 32'd0, (i == 0));
                  end
               end
            end
            MODE_SIZE: begin
               sum = {1'b0, pos} + 21'(n);
               pos = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[19:0];
               push(KIND_SIZE, 8'd0, 32'(n), 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [2:0] k, logic [7:0] b, logic [31:0] v,
                                 logic [19:0] p, logic lst);
         codec_beat_type want;
         if (pending_beats.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: unexpected beat kind %0d byte %02h value %08h pos %05h last %0b",
                        k, b, v, p, lst);
            return;
         end
         want = pending_beats.pop_front();
         checked++;
         kind_seen[int'(want.kind)]++;
         if (k !== want.kind || b !== want.out_byte || v !== want.value ||
             p !== want.position || lst !== want.last) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $write("ERROR: beat %0d expected kind %0d byte %02h value %08h pos %05h last %0b,",
                      checked, want.kind, want.out_byte, want.value, want.position,
                      want.last);
               $display(" got kind %0d byte %02h value %08h pos %05h last %0b",
                        k, b, v, p, lst);
            end
         end
      endfunction
   endclass

   logic                     clock        = 1'b0;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic                     req_stall;
   logic                     req_restart  = 1'b0;
   logic [7:0]               req_in_byte  = '0;
   logic [31:0]              req_in_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall    = 1'b0;
   logic [2:0]               rsp_out_kind;
   logic [7:0]               rsp_out_byte;
   logic [31:0]              rsp_out_value;
   logic [19:0]              rsp_position;
   logic                     rsp_last;
   logic                     csr_write_en = 1'b0;
   logic                     csr_index    = CSR_MODE;
   logic [CSR_DATA_BITS-1:0] csr_wdata    = '0;

   bit                  gaps_on   = 1'b0;
   bit                  stalls_on = 1'b0;
   int                  cycle_count = 0;
   uintvar_tracker_type tracker;

   uintvar_stream_codec_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_restart   (req_restart),
      .req_in_byte   (req_in_byte),
      .req_in_value  (req_in_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_value (rsp_out_value),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("uintvar_stream_codec_top verification failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= stalls_on && ($urandom_range(0, 99) < 17);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_out_kind, rsp_out_byte, rsp_out_value, rsp_position, rsp_last);
   end

   task automatic send_item(input logic rs, input logic [7:0] b, input logic [31:0] v);
      if (gaps_on && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_restart  <= rs;
      req_in_byte  <= b;
      req_in_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.accept_item(rs, b, v);
   endtask

   // drop valid and let every queued beat come back
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      tracker.set_reg(idx, data);
   endtask

   task automatic configure(input logic [1:0] m, input logic [15:0] len, input bit junk);
      drain();
      write_reg(CSR_MODE, {(junk ? 14'($urandom) : 14'd0), m});
      write_reg(CSR_BUFLEN, len);
   endtask

   task automatic send_decode_run(input int len, input logic rs);
      logic [7:0] b;
      int         i;
      for (i = 0; i < len; i++) begin
         b    = 8'($urandom);
         b[7] = (i != len - 1);
         send_item(rs && i == 0, b, $urandom);
      end
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      int          groups;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 8))
            0: v = 32'h0;
            1: v = 32'h7f;
            2: v = 32'h80;
            3: v = 32'h3fff;
            4: v = 32'h4000;
            5: v = 32'h1fffff;
            6: v = 32'h200000;
            7: v = 32'hfffffff;
            default: v = 32'h10000000;
         endcase
         return v;
      end
      groups = $urandom_range(1, 5);
      v = $urandom;
      if (groups < 5) v = v & ((32'd1 << (7 * groups)) - 1);
      if (groups > 1) v = v | (32'd1 << (7 * (groups - 1)));
      return v;
   endfunction

   initial begin
      logic [1:0]  m;
      logic [15:0] len;
      int          r;
      int          phase;
      int          phase_items;
      int          random_items;
      int          run_len;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gaps_on = 1'b1;
      stalls_on <= 1'b1;

      // decode corners at the reset settings
      send_item(1'b0, 8'h00, 32'hffffffff);
      send_item(1'b0, 8'h7f, 32'h0);
      send_item(1'b0, 8'hff, 32'h0);
      send_item(1'b0, 8'h80, 32'h0);
      send_item(1'b0, 8'h80, 32'h0);
      send_item(1'b0, 8'h80, 32'h0);
      send_item(1'b0, 8'h00, 32'h0);
      repeat (5) send_item(1'b0, 8'h80, 32'h0);
      send_item(1'b0, 8'h01, 32'h0);
      send_item(1'b0, 8'h85, 32'h0);
      send_item(1'b1, 8'h05, 32'h0);
      configure(MODE_DECODE, 16'd1, 1'b0);
      send_item(1'b1, 8'h00, 32'h0);
      send_item(1'b0, 8'h81, 32'h0);

      configure(MODE_ENCODE, 16'hffff, 1'b0);
      send_item(1'b1, 8'hff, 32'h0);
      send_item(1'b0, 8'h00, 32'hffffffff);
      send_item(1'b0, 8'h00, 32'h3fff);
      send_item(1'b0, 8'h00, 32'h200000);
      configure(MODE_ENCODE, 16'd3, 1'b0);
      send_item(1'b1, 8'h00, 32'hffffffff);
      configure(MODE_SIZE, 16'd3, 1'b0);
      send_item(1'b1, 8'h00, 32'hffffffff);
      configure(MODE_ENCODE, 16'd3, 1'b0);
      send_item(1'b0, 8'h00, 32'h0);
      configure(MODE_UNUSED, 16'd3, 1'b0);
      send_item(1'b1, 8'h81, 32'h12345678);
      configure(MODE_DECODE, 16'd0, 1'b0);
      send_item(1'b0, 8'h01, 32'h0);

      // run size mode back to back, no idling
      configure(MODE_SIZE, 16'hffff, 1'b0);
      gaps_on = 1'b0;
      stalls_on <= 1'b0;
      send_item(1'b1, 8'h00, 32'hffffffff);
      repeat (BURST_ITEMS - 1) send_item(1'b0, 8'($urandom), $urandom | 32'h10000000);
      send_item(1'b0, 8'h00, 32'h0);

      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         r = $urandom_range(0, 99);
         if (r < 40) m = MODE_DECODE;
         else if (r < 70) m = MODE_ENCODE;
         else if (r < 95) m = MODE_SIZE;
         else m = MODE_UNUSED;
         case ($urandom_range(0, 4))
            0: len = 16'd0;
            1: len = 16'($urandom_range(1, 8));
            2: len = 16'($urandom_range(9, 300));
            3: len = 16'hffff;
            default: len = 16'($urandom);
         endcase
         configure(m, len, 1'b1);
         gaps_on = (phase % 4 != 2);
         stalls_on <= (phase % 4 != 2);
         phase_items = 0;
         if (m == MODE_UNUSED) begin
            repeat (3) send_item(1'($urandom), 8'($urandom), $urandom);
         end else begin
            while (phase_items < PHASE_ITEMS) begin
               if (m != MODE_DECODE) begin
                  send_item($urandom_range(0, 9) == 0, 8'($urandom), pick_value());
                  phase_items++;
               end else if ($urandom_range(0, 99) < 15) begin
                  send_item(1'($urandom), 8'($urandom), $urandom);
                  phase_items++;
               end else begin
                  run_len = ($urandom_range(0, 99) < 12) ? $urandom_range(6, 7)
                                                        : $urandom_range(1, 5);
                  send_decode_run(run_len, $urandom_range(0, 9) == 0);
                  phase_items += run_len;
               end
            end
         end
         random_items += phase_items;
      end

      drain();
      $display("Covered %0d input beats over %0d random phases, %0d result beats checked",
               tracker.items_seen, phase, tracker.checked);
      $display("  values %0d, bytes %0d, sizes %0d, no-room %0d, too-long %0d, failures %0d",
               tracker.kind_seen[KIND_VALUE], tracker.kind_seen[KIND_BYTE],
               tracker.kind_seen[KIND_SIZE], tracker.kind_seen[KIND_NOROOM],
               tracker.kind_seen[KIND_TOOLONG], tracker.failures);
      if (tracker.failures == 0 && tracker.pending_beats.size() == 0) begin
         $display("uintvar_stream_codec_top verification clean");
      end else begin
         $display("uintvar_stream_codec_top verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/uvsc_pkg.sv
hw/rtl/uvsc_ctrl.sv
hw/rtl/uvsc_dp.sv
hw/rtl/uintvar_stream_codec_top.sv
tb/sv/tb_uintvar_stream_codec_top.sv
